FILE: rtl/vtg_pkg.sv
// ----------------------------------------------------------------------------
// vtg_pkg
// Shared types, widths, register codes and the power-curve table function
// for the vorticity-to-gray pixel core.
// ----------------------------------------------------------------------------
package vtg_pkg;

  localparam int COORD_W    = 12;
  localparam int FLAG_W     = 8;
  localparam int VEL_W      = 32;
  localparam int INV_W      = 32;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int POW_TABLE_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF       = 16;

  // 255 to the fifth power.
  localparam longint unsigned P255_5 = 64'd1078203909375;

  typedef enum logic [CFG_IDX_W-1:0] {
    RegGridWidth     = 3'd0,
    RegGridHeight    = 3'd1,
    RegInvCellWidth  = 3'd2,
    RegInvCellHeight = 3'd3,
    RegFluidMask     = 3'd4
  } vtg_reg_e;

  typedef struct packed {
    logic        [COORD_W-1:0] col_index;
    logic        [COORD_W-1:0] row_index;
    logic        [FLAG_W-1:0]  cell_flag;
    logic        [FLAG_W-1:0]  right_flag;
    logic        [FLAG_W-1:0]  upper_flag;
    logic        [FLAG_W-1:0]  corner_flag;
    logic signed [VEL_W-1:0]   u_here;
    logic signed [VEL_W-1:0]   u_above;
    logic signed [VEL_W-1:0]   v_here;
    logic signed [VEL_W-1:0]   v_right;
  } vtg_cell_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } vtg_pixel_t;

  // Largest g in 0..255 with g^5 * depth^2 <= k^2 * 255^5, found bit by bit.
  function automatic logic [PIX_W-1:0] pow_entry(input int unsigned k,
                                                 input int unsigned depth);
    logic [79:0]      lhs;
    logic [79:0]      rhs;
    logic [79:0]      c;
    logic [PIX_W-1:0] ent;
    logic [PIX_W-1:0] cand;
    ent = '0;
    rhs = 80'(k) * 80'(k) * 80'(P255_5);
    for (int b = PIX_W - 1; b >= 0; b--) begin
      cand = ent | PIX_W'(1 << b);
      c    = 80'(cand);
      lhs  = c * c * c * c * c * 80'(depth) * 80'(depth);
      if (lhs <= rhs) begin
        ent = cand;
      end
    end
    return ent;
  endfunction

endpackage

FILE: rtl/vtg_stream_if.sv
// ----------------------------------------------------------------------------
// vtg_stream_if
// Valid/ready stream channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface vtg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/vtg_pow_rom.sv
// ----------------------------------------------------------------------------
// vtg_pow_rom
// Constant gray-level table for 255 * x^0.4 with a registered read port.
// ----------------------------------------------------------------------------
module vtg_pow_rom #(
  parameter int Depth = vtg_pkg::POW_TABLE_DEPTH_DEF,
  parameter int IdxW  = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [IdxW-1:0]         idx_i,
  output logic [vtg_pkg::PIX_W-1:0] gray_o
);
  import vtg_pkg::*;

  logic [PIX_W-1:0] rom_w [Depth];
  logic [PIX_W-1:0] gray_q;

  // Entries are evaluated at elaboration, so each is a constant.
  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic [PIX_W-1:0] Entry = pow_entry(k, Depth);
    assign rom_w[k] = Entry;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gray_q <= rom_w[idx_i];
    end
  end

  assign gray_o = gray_q;

endmodule

FILE: rtl/vorticity_to_gray_pixel_core.sv
// ----------------------------------------------------------------------------
// vorticity_to_gray_pixel_core
// Turns one grid cell per request into one RGB pixel showing |vorticity|.
//
// Usage: cell requests enter on cell_i (valid/ready); each carries the cell
// coordinates, four flag bytes and four Q16.16 velocity samples. Exactly one
// pixel request leaves on pixel_o per accepted cell, in order. Non-fluid
// cells give a green pixel; fluid cells give a gray level on all three
// channels, 255 * (|z| / 12.6)^0.4, saturating at 255.
// Each accepted cell passes through stages 1 to 7 in order. Throughput is
// one cell per cycle while the receiver does not stall; the rate is set by
// the seven-stage pipeline with one 32x32 multiplier pair, one reciprocal
// multiply and one table read per stage slot, each stage holding one cell.
// The configuration port writes one register per cycle with cfg_we_i; it is
// to be written only while no cell is in flight.
// Reset clears all stage valid bits and loads the register reset values
// (grid 128 x 128, unit reciprocals, fluid mask 0x10).
// When the receiver stalls, the output stage holds its pixel; earlier stages
// keep advancing into empty slots, and cell_i.ready drops only once every
// stage holds a cell, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vorticity_to_gray_pixel_core #(
  parameter int POW_TABLE_DEPTH = vtg_pkg::POW_TABLE_DEPTH_DEF,
  parameter int FRAC_BITS       = vtg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vtg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vtg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  vtg_stream_if.sink                      cell_i,
  vtg_stream_if.source                    pixel_o
);
  import vtg_pkg::*;

  // Fixed-point form of 12.6 and the widths that follow from it.
  localparam longint unsigned ZMax = (64'd126 << FRAC_BITS) / 64'd10;
  localparam int ZW     = $clog2(ZMax);
  localparam int IdxW   = $clog2(POW_TABLE_DEPTH);
  localparam int NW     = $clog2(ZMax * POW_TABLE_DEPTH);
  // Reciprocal of ZMax scaled by 2^NW; the quotient estimate is low by at
  // most one, which the next stage corrects.
  localparam longint unsigned Recip  = (64'd1 << NW) / ZMax;
  localparam longint unsigned KConst = Recip * POW_TABLE_DEPTH;
  localparam int QW     = NW + IdxW;
  localparam int ProdW  = 2 * VEL_W - FRAC_BITS;
  localparam int ZsW    = ProdW + 2;
  localparam int AzW    = ProdW + 1;
  localparam int NumStages = 7;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] grid_w_q, grid_h_q;
  logic [INV_W-1:0]   inv_w_q, inv_h_q;
  logic [FLAG_W-1:0]  fmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= COORD_W'(128);
      grid_h_q <= COORD_W'(128);
      inv_w_q  <= INV_W'(65536);
      inv_h_q  <= INV_W'(65536);
      fmask_q  <= FLAG_W'(16);
    end else if (cfg_we_i) begin
      case (vtg_reg_e'(cfg_index_i))
        RegGridWidth:     grid_w_q <= cfg_wdata_i[COORD_W-1:0];
        RegGridHeight:    grid_h_q <= cfg_wdata_i[COORD_W-1:0];
        RegInvCellWidth:  inv_w_q  <= cfg_wdata_i[INV_W-1:0];
        RegInvCellHeight: inv_h_q  <= cfg_wdata_i[INV_W-1:0];
        RegFluidMask:     fmask_q  <= cfg_wdata_i[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or its successor loads,
  // which squeezes bubbles out while the receiver stalls.
  // --------------------------------------------------------------------------
  logic [NumStages:1]   valid_q;
  logic [NumStages:0]   valid_in;
  logic [NumStages+1:1] en;

  always_comb begin
    en[NumStages+1] = pixel_o.ready;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign valid_in = {valid_q, cell_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k-1];
        end
      end
    end
  end

  assign cell_i.ready = en[1];

  // --------------------------------------------------------------------------
  // Stage 1: fluid checks and velocity differences as sign and magnitude.
  // Outside the grid or next to a non-fluid cell both differences are
  // forced to zero, which gives a zero vorticity.
  // --------------------------------------------------------------------------
  logic               nonfluid_w, active_w;
  logic signed [VEL_W:0] du_w, dv_w;
  logic [VEL_W-1:0]   du_mag_w, dv_mag_w;

  logic               s1_nonfluid_q, s1_du_neg_q, s1_dv_neg_q;
  logic [VEL_W-1:0]   s1_du_mag_q, s1_dv_mag_q;

  always_comb begin
    nonfluid_w = (cell_i.payload.cell_flag & fmask_q) == '0;
    active_w   = (cell_i.payload.col_index < grid_w_q) &&
                 (cell_i.payload.row_index < grid_h_q) &&
                 ((cell_i.payload.right_flag & fmask_q) != '0) &&
                 ((cell_i.payload.upper_flag & fmask_q) != '0) &&
                 ((cell_i.payload.corner_flag & fmask_q) != '0);
    du_w = (VEL_W+1)'(cell_i.payload.u_above) - (VEL_W+1)'(cell_i.payload.u_here);
    dv_w = (VEL_W+1)'(cell_i.payload.v_right) - (VEL_W+1)'(cell_i.payload.v_here);
    du_mag_w = du_w[VEL_W] ? VEL_W'(-du_w) : du_w[VEL_W-1:0];
    dv_mag_w = dv_w[VEL_W] ? VEL_W'(-dv_w) : dv_w[VEL_W-1:0];
    if (!active_w) begin
      du_mag_w = '0;
      dv_mag_w = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_nonfluid_q <= nonfluid_w;
      s1_du_neg_q   <= du_w[VEL_W];
      s1_dv_neg_q   <= dv_w[VEL_W];
      s1_du_mag_q   <= du_mag_w;
      s1_dv_mag_q   <= dv_mag_w;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale each magnitude by its reciprocal spacing and truncate to
  // the working fraction.
  // --------------------------------------------------------------------------
  logic [2*VEL_W-1:0] prod_u_w, prod_v_w;
  logic               s2_nonfluid_q, s2_u_neg_q, s2_v_neg_q;
  logic [ProdW-1:0]   s2_tu_q, s2_tv_q;

  assign prod_u_w = (2*VEL_W)'(s1_du_mag_q) * (2*VEL_W)'(inv_h_q);
  assign prod_v_w = (2*VEL_W)'(s1_dv_mag_q) * (2*VEL_W)'(inv_w_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_nonfluid_q <= s1_nonfluid_q;
      s2_u_neg_q    <= s1_du_neg_q;
      s2_v_neg_q    <= s1_dv_neg_q;
      s2_tu_q       <= prod_u_w[2*VEL_W-1:FRAC_BITS];
      s2_tv_q       <= prod_v_w[2*VEL_W-1:FRAC_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: signed vorticity z = du/dy - dv/dx.
  // --------------------------------------------------------------------------
  logic signed [ZsW-1:0] tu_s_w, tv_s_w;
  logic                  s3_nonfluid_q;
  logic signed [ZsW-1:0] s3_z_q;

  always_comb begin
    tu_s_w = $signed({2'b00, s2_tu_q});
    tv_s_w = $signed({2'b00, s2_tv_q});
    if (s2_u_neg_q) tu_s_w = -tu_s_w;
    if (s2_v_neg_q) tv_s_w = -tv_s_w;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_nonfluid_q <= s2_nonfluid_q;
      s3_z_q        <= tu_s_w - tv_s_w;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitude and saturation test against 12.6.
  // --------------------------------------------------------------------------
  logic [ZsW-1:0] z_abs_w;
  logic [AzW-1:0] az_w;
  logic           s4_nonfluid_q, s4_sat_q;
  logic [ZW-1:0]  s4_az_q;

  assign z_abs_w = s3_z_q[ZsW-1] ? ZsW'(-s3_z_q) : ZsW'(s3_z_q);
  assign az_w    = z_abs_w[AzW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_nonfluid_q <= s3_nonfluid_q;
      s4_sat_q      <= az_w >= AzW'(ZMax);
      s4_az_q       <= az_w[ZW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: quotient estimate of |z| * depth / ZMax by reciprocal multiply.
  // For unsaturated cells the product stays below 2^(NW+IdxW), so QW bits hold it exactly.
  // --------------------------------------------------------------------------
  logic [QW-1:0]   qprod_w;
  logic            s5_nonfluid_q, s5_sat_q;
  logic [ZW-1:0]   s5_az_q;
  logic [IdxW-1:0] s5_qe_q;

  assign qprod_w = QW'(s4_az_q) * QW'(KConst);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_nonfluid_q <= s4_nonfluid_q;
      s5_sat_q      <= s4_sat_q;
      s5_az_q       <= s4_az_q;
      s5_qe_q       <= qprod_w[NW +: IdxW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: remainder check, bumping the estimate when it fell one short.
  // --------------------------------------------------------------------------
  logic [NW-1:0]   num_w, rem_w;
  logic [IdxW-1:0] idx_w;
  logic            s6_nonfluid_q, s6_sat_q;
  logic [IdxW-1:0] s6_idx_q;

  assign num_w = NW'(s5_az_q) * NW'(POW_TABLE_DEPTH);
  assign rem_w = num_w - NW'(s5_qe_q) * NW'(ZMax);
  assign idx_w = (rem_w >= NW'(ZMax)) ? s5_qe_q + IdxW'(1) : s5_qe_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_nonfluid_q <= s5_nonfluid_q;
      s6_sat_q      <= s5_sat_q;
      s6_idx_q      <= idx_w;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: table read into the output register, plus the pixel flags.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] gray_w;
  logic             out_nonfluid_q, out_sat_q;
  logic [PIX_W-1:0] level_w;

  vtg_pow_rom #(
    .Depth (POW_TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_pow_rom (
    .clk_i  (clk_i),
    .en_i   (en[7]),
    .idx_i  (s6_idx_q),
    .gray_o (gray_w)
  );

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      out_nonfluid_q <= s6_nonfluid_q;
      out_sat_q      <= s6_sat_q;
    end
  end

  assign level_w = out_sat_q ? '1 : gray_w;

  assign pixel_o.valid         = valid_q[NumStages];
  assign pixel_o.payload.red   = out_nonfluid_q ? '0 : level_w;
  assign pixel_o.payload.green = out_nonfluid_q ? '1 : level_w;
  assign pixel_o.payload.blue  = out_nonfluid_q ? '0 : level_w;

endmodule
